// ===== rtl/ced_pkg.sv =====
package ced_pkg;

    // Scheduler dimensions.
    localparam int LEVELS = 8;
    localparam int TASKS  = 8;
    localparam int NCHAN  = 3;

    localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int TW = (TASKS > 1) ? $clog2(TASKS) : 1;
    localparam int CW = 2;

    localparam logic [15:0] CNT_MAX = 16'hFFFF;

    // Configuration register indexes.
    localparam logic [1:0] REG_DEBOUNCE = 2'd0;
    localparam logic [1:0] REG_CHAN0_LEVEL = 2'd1;
    localparam logic [1:0] REG_CHAN1_LEVEL = 2'd2;
    localparam logic [1:0] REG_CHAN2_LEVEL = 2'd3;

    localparam logic [15:0] DEBOUNCE_RESET = 16'd400;
    localparam logic [2:0] CHAN0_LEVEL_RESET = 3'd7;
    localparam logic [2:0] CHAN1_LEVEL_RESET = 3'd5;
    localparam logic [2:0] CHAN2_LEVEL_RESET = 3'd3;

    // A channel code that names no channel.
    localparam logic [CW-1:0] CHAN_NONE = 2'd3;

    typedef enum logic [0:0] {
        OP_PRESS    = 1'b0,
        OP_DISPATCH = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        K_DROPPED  = 2'd0,
        K_QUEUED   = 2'd1,
        K_REGULAR  = 2'd2,
        K_SPORADIC = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        PH_REGULAR  = 2'd0,
        PH_SPORADIC = 2'd1
    } t_phase;

    typedef struct packed {
        t_op         operation;
        logic [1:0]  channel;
        logic [31:0] time_ms;
    } t_in_word;

    typedef struct packed {
        t_kind       kind;
        logic [2:0]  level;
        logic [15:0] job_number;
        logic [1:0]  job_channel;
    } t_out_word;

    typedef struct packed {
        logic [15:0]             press_gap_ms;
        logic [NCHAN-1:0][2:0]   chan_level;
    } t_cfg;

    typedef struct packed {
        t_phase phase;
        logic   snap_any;
    } t_sched_status;

endpackage

// ===== rtl/ced_cfg.sv =====
module ced_cfg import ced_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_wr_en,
    input  logic [1:0]  i_wr_index,
    input  logic [15:0] i_wr_data,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.press_gap_ms  <= DEBOUNCE_RESET;
            r_cfg.chan_level[0] <= CHAN0_LEVEL_RESET;
            r_cfg.chan_level[1] <= CHAN1_LEVEL_RESET;
            r_cfg.chan_level[2] <= CHAN2_LEVEL_RESET;
        end else if (i_wr_en) begin
            case (i_wr_index)
                REG_DEBOUNCE:    r_cfg.press_gap_ms  <= i_wr_data;
                REG_CHAN0_LEVEL: r_cfg.chan_level[0] <= i_wr_data[2:0];
                REG_CHAN1_LEVEL: r_cfg.chan_level[1] <= i_wr_data[2:0];
                REG_CHAN2_LEVEL: r_cfg.chan_level[2] <= i_wr_data[2:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/ced_core.sv =====
module ced_core import ced_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_fire,
    input  t_in_word      i_word,
    input  t_cfg          i_cfg,
    output t_out_word     o_result,
    output t_sched_status o_status
);

    logic [NCHAN-1:0][31:0] r_last, n_last;
    logic [NCHAN-1:0][15:0] r_pending, n_pending;
    logic [NCHAN-1:0][15:0] r_queued, n_queued;
    logic [NCHAN-1:0][15:0] r_exec, n_exec;
    logic [NCHAN-1:0][15:0] r_snap, n_snap;
    logic [LW-1:0]          r_level, n_level;
    logic [TW-1:0]          r_slot, n_slot;
    t_phase                 r_phase, n_phase;

    function automatic logic [LW-1:0] next_lvl(input logic [LW-1:0] lvl);
        return (lvl == LW'(LEVELS - 1)) ? '0 : lvl + 1'b1;
    endfunction

    function automatic logic [2:0] low3(input logic [LW-1:0] lvl);
        logic [LW+2:0] wide;
        wide = {3'b000, lvl};
        return wide[2:0];
    endfunction

    always_comb begin
        logic [1:0]             ch;
        logic [31:0]            diff;
        logic                   snap_any;
        logic [LW-1:0]          e_level;
        logic [TW-1:0]          e_slot;
        t_phase                 e_phase;
        logic [NCHAN-1:0][15:0] snap_w;
        logic                   w_any;
        logic [31:0]            id;
        logic [1:0]             first;
        logic                   left_any;

        n_last    = r_last;
        n_pending = r_pending;
        n_queued  = r_queued;
        n_exec    = r_exec;
        n_snap    = r_snap;
        n_level   = r_level;
        n_slot    = r_slot;
        n_phase   = r_phase;
        o_result  = '0;

        ch       = i_word.channel;
        diff     = '0;
        left_any = 1'b0;
        snap_any = 1'b0;
        for (int c = 0; c < NCHAN; c++) begin
            snap_any = snap_any | (r_snap[c] != '0);
        end

        // The sporadic phase never runs with an empty snapshot; should it, the
        // request is served as the first task of the next level.
        if (r_phase == PH_SPORADIC && !snap_any) begin
            e_level = next_lvl(r_level);
            e_slot  = '0;
            e_phase = PH_REGULAR;
        end else begin
            e_level = r_level;
            e_slot  = r_slot;
            e_phase = r_phase;
        end

        snap_w = r_snap;
        if (e_slot == '0) begin
            for (int c = 0; c < NCHAN; c++) begin
                snap_w[c] = ({{LW{1'b0}}, i_cfg.chan_level[c]} == {3'b000, e_level}) ?
                            r_pending[c] : 16'd0;
            end
        end
        w_any = 1'b0;
        for (int c = 0; c < NCHAN; c++) begin
            w_any = w_any | (snap_w[c] != '0);
        end
        id = 32'(e_level) * 32'(TASKS) + 32'(e_slot);

        first = CHAN_NONE;
        for (int c = NCHAN - 1; c >= 0; c--) begin
            if (r_snap[c] != '0) begin
                first = 2'(c);
            end
        end

        if (i_fire) begin
            if (i_word.operation == OP_PRESS) begin
                if (ch == CHAN_NONE) begin
                    o_result.kind = K_DROPPED;
                end else begin
                    diff = i_word.time_ms - r_last[ch];
                    o_result.level       = i_cfg.chan_level[ch];
                    o_result.job_channel = ch;
                    if (diff < {16'd0, i_cfg.press_gap_ms}) begin
                        o_result.kind       = K_DROPPED;
                        o_result.job_number = r_queued[ch];
                    end else begin
                        n_last[ch] = i_word.time_ms;
                        if (r_pending[ch] != CNT_MAX) begin
                            n_pending[ch] = r_pending[ch] + 16'd1;
                        end
                        if (r_queued[ch] != CNT_MAX) begin
                            n_queued[ch] = r_queued[ch] + 16'd1;
                        end
                        o_result.kind       = K_QUEUED;
                        o_result.job_number = n_queued[ch];
                    end
                end
            end else if (e_phase != PH_SPORADIC) begin
                o_result.kind       = K_REGULAR;
                o_result.level      = low3(e_level);
                o_result.job_number = id[15:0];
                n_snap = snap_w;
                if (e_slot == TW'(TASKS - 1)) begin
                    n_slot = '0;
                    if (w_any) begin
                        n_phase = PH_SPORADIC;
                        n_level = e_level;
                    end else begin
                        n_phase = PH_REGULAR;
                        n_level = next_lvl(e_level);
                    end
                end else begin
                    n_slot  = e_slot + 1'b1;
                    n_level = e_level;
                    n_phase = PH_REGULAR;
                end
            end else begin
                o_result.kind        = K_SPORADIC;
                o_result.level       = low3(r_level);
                o_result.job_number  = r_exec[first];
                o_result.job_channel = first;
                n_exec[first] = r_exec[first] + 16'd1;
                if (r_pending[first] != '0) begin
                    n_pending[first] = r_pending[first] - 16'd1;
                end
                n_snap[first] = r_snap[first] - 16'd1;
                left_any = 1'b0;
                for (int c = 0; c < NCHAN; c++) begin
                    left_any = left_any | (n_snap[c] != '0);
                end
                if (!left_any) begin
                    n_level = next_lvl(r_level);
                    n_slot  = '0;
                    n_phase = PH_REGULAR;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NCHAN; c++) begin
                r_last[c]    <= '0;
                r_pending[c] <= '0;
                r_queued[c]  <= '0;
                r_exec[c]    <= 16'd1;
                r_snap[c]    <= '0;
            end
            r_level <= '0;
            r_slot  <= '0;
            r_phase <= PH_REGULAR;
        end else begin
            r_last    <= n_last;
            r_pending <= n_pending;
            r_queued  <= n_queued;
            r_exec    <= n_exec;
            r_snap    <= n_snap;
            r_level   <= n_level;
            r_slot    <= n_slot;
            r_phase   <= n_phase;
        end
    end

    always_comb begin
        o_status.phase    = r_phase;
        o_status.snap_any = 1'b0;
        for (int c = 0; c < NCHAN; c++) begin
            o_status.snap_any = o_status.snap_any | (r_snap[c] != '0);
        end
    end

endmodule

// ===== rtl/cyclic_executive_sporadic_dispatch_top.sv =====
// A word accepted into the input register moves through the core into the result register.
// Throughput: one word per cycle while the output is not stalled, set by the single
// state-update pass in the core between the input register and the result register.
// Reset: synchronous, active low; clears both pipeline valids, the level/slot/phase state
// and the channel counters but the execution counts, set to 1; loads the config defaults.
module cyclic_executive_sporadic_dispatch_top import ced_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  t_in_word    i_in_data,
    output logic        o_in_stall,
    output logic        o_out_valid,
    output t_out_word   o_out_data,
    input  logic        i_out_stall,
    input  logic        i_cfg_valid,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output logic        o_cfg_ready
);

    // The input register holds one word in front of the core. The core works on
    // it in the cycle it fires and writes its result into the result register.
    logic          r_in_valid;
    t_in_word      r_in;
    logic          r_out_valid;
    t_out_word     r_out;
    logic          advance;
    logic          fire;
    t_out_word     result;
    t_cfg          cfg;
    t_sched_status status;

    // The result register can take a new result when it is empty or its word is
    // leaving this cycle; only then does the held input word move on.
    assign advance    = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;

    // Configuration writes are always taken.
    assign o_cfg_ready = 1'b1;

    ced_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid && o_cfg_ready),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    ced_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_word   (r_in),
        .i_cfg    (cfg),
        .o_result (result),
        .o_status (status)
    );

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && !o_in_stall) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_data;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // The sporadic phase is only ever entered with work in the snapshot and is
    // left the moment the snapshot empties.
    a_spor_has_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.phase == PH_SPORADIC |-> status.snap_any)
        else $error("sporadic phase with an empty snapshot");

    // A regular task never carries a channel.
    a_regular_no_chan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.kind == K_REGULAR |-> r_out.job_channel == '0)
        else $error("regular task reported with a channel");

    // The input side only stalls when the result register is full and held.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid && r_out_valid && i_out_stall)
        else $error("input stalled without a held result");

    // A word fired into the core shows up as a valid result on the next edge.
    a_fire_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> r_out_valid)
        else $error("fired word produced no result");

endmodule
